### sv/mlfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_pkg
// shared types and constants of the three-level feedback queue scheduler
// ----------------------------------------------------------------------------
package mlfq_pkg;

   localparam int JOB_SLOTS_DEF = 16;

   localparam logic [1:0] TOP_LEVEL = 2'd2;
   localparam logic [3:0] CNT_MAX   = 4'd15;

   localparam int REQ_W = 24;
   localparam int RSP_W = 40;
   localparam int CFG_W = 4;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_ENQ    = 2'd1,
      OP_DEQ    = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CFG_SLICE0 = 2'd0,
      CFG_SLICE1 = 2'd1,
      CFG_SLICE2 = 2'd2,
      CFG_AGING  = 2'd3
   } cfg_index_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_RELEASE,
      CMD_TICK,
      CMD_WALK_INIT,
      CMD_NEXT_LV,
      CMD_MEM_RD,
      CMD_AGE_EX,
      CMD_AGE_PUSH,
      CMD_SCAN,
      CMD_DEQ_EX,
      CMD_NOT_FOUND,
      CMD_SEL_NONE,
      CMD_SEL_RD,
      CMD_SEL_EX,
      CMD_SEL_PUSH,
      CMD_OUT
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   p_none;
      logic   lv_zero;
      logic   promote;
      logic   scan_free;
      logic   scan_last;
      logic   run_vld;
      logic   run_match;
      logic   id_match;
      logic   need_sel;
      logic   pick_ok;
      logic   out_free;
   } stat_type;

endpackage

### sv/mlfq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_ctrl
// sequencer that steps one request through aging (skipped on finish), command and selection
// ----------------------------------------------------------------------------
module mlfq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output mlfq_pkg::cmd_type cmd,
   input  mlfq_pkg::stat_type stat
);
   import mlfq_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE      = 14'b00000000000001,
      S_DECODE    = 14'b00000000000010,
      S_AGE_CHK   = 14'b00000000000100,
      S_AGE_EX    = 14'b00000000001000,
      S_AGE_PUSH  = 14'b00000000010000,
      S_OPS       = 14'b00000000100000,
      S_SCAN      = 14'b00000001000000,
      S_DEQ_START = 14'b00000010000000,
      S_DEQ_CHK   = 14'b00000100000000,
      S_DEQ_EX    = 14'b00001000000000,
      S_SEL_CHK   = 14'b00010000000000,
      S_SEL_EX    = 14'b00100000000000,
      S_SEL_PUSH  = 14'b01000000000000,
      S_OUT       = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd      = CMD_ACCEPT;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.op == OP_FINISH) begin
               cmd      = CMD_RELEASE;
               state_in = S_SEL_CHK;
            end else begin
               cmd      = CMD_TICK;
               state_in = S_AGE_CHK;
            end
         end
         S_AGE_CHK: begin
            if (stat.p_none) begin
               if (stat.lv_zero) state_in = S_OPS;
               else cmd = CMD_NEXT_LV;
            end else begin
               cmd      = CMD_MEM_RD;
               state_in = S_AGE_EX;
            end
         end
         S_AGE_EX: begin
            cmd      = CMD_AGE_EX;
            state_in = stat.promote ? S_AGE_PUSH : S_AGE_CHK;
         end
         S_AGE_PUSH: begin
            cmd      = CMD_AGE_PUSH;
            state_in = S_AGE_CHK;
         end
         S_OPS: begin
            case (stat.op)
               OP_ENQ:  state_in = S_SCAN;
               OP_DEQ:  state_in = S_DEQ_START;
               default: state_in = S_SEL_CHK;
            endcase
         end
         S_SCAN: begin
            cmd = CMD_SCAN;
            if (stat.scan_free || stat.scan_last) state_in = S_SEL_CHK;
         end
         S_DEQ_START: begin
            if (stat.run_match) begin
               cmd      = CMD_RELEASE;
               state_in = S_SEL_CHK;
            end else begin
               cmd      = CMD_WALK_INIT;
               state_in = S_DEQ_CHK;
            end
         end
         S_DEQ_CHK: begin
            if (stat.p_none) begin
               if (stat.lv_zero) begin
                  cmd      = CMD_NOT_FOUND;
                  state_in = S_SEL_CHK;
               end else begin
                  cmd = CMD_NEXT_LV;
               end
            end else begin
               cmd      = CMD_MEM_RD;
               state_in = S_DEQ_EX;
            end
         end
         S_DEQ_EX: begin
            cmd      = CMD_DEQ_EX;
            state_in = stat.id_match ? S_SEL_CHK : S_DEQ_CHK;
         end
         S_SEL_CHK: begin
            if (stat.need_sel && stat.pick_ok) begin
               cmd      = CMD_SEL_RD;
               state_in = S_SEL_EX;
            end else if (stat.need_sel) begin
               cmd      = CMD_SEL_NONE;
               state_in = S_OUT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_SEL_EX: begin
            cmd      = CMD_SEL_EX;
            state_in = stat.run_vld ? S_SEL_PUSH : S_OUT;
         end
         S_SEL_PUSH: begin
            cmd      = CMD_SEL_PUSH;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd      = CMD_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

### sv/mlfq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_dpath
// slot table, level lists, running job and result register
// ----------------------------------------------------------------------------
module mlfq_dpath #(
   parameter int JOB_SLOTS = mlfq_pkg::JOB_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mlfq_pkg::REQ_W-1:0]  req_tdata,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [mlfq_pkg::CFG_W-1:0]  csr_wdata,
   input  mlfq_pkg::cmd_type           cmd,
   output mlfq_pkg::stat_type          stat,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [mlfq_pkg::RSP_W-1:0]  rsp_tdata
);
   import mlfq_pkg::*;

   localparam int SW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
   localparam logic [SW-1:0] LAST_SLOT = SW'(JOB_SLOTS - 1);

   // configuration
   logic [3:0] slice_ff [3];
   logic [3:0] aging_ff;

   // latched request
   op_type      op_ff;
   logic [1:0]  pr_ff;
   logic [15:0] id_ff;

   // level lists
   logic [2:0]    head_none_ff, tail_none_ff;
   logic [SW-1:0] head_ff [3];
   logic [SW-1:0] tail_ff [3];

   // running job
   logic          run_vld_ff;
   logic [SW-1:0] run_slot_ff;
   logic [15:0]   run_ident_ff;
   logic [1:0]    run_level_ff, run_base_ff;
   logic [3:0]    slice_used_ff;
   logic [15:0]   last_ident_ff;
   logic [JOB_SLOTS-1:0] used_ff;

   // walk cursor
   logic [1:0]    lv_ff;
   logic          p_none_ff, prev_none_ff;
   logic [SW-1:0] p_ff, prev_ff, pp_ff, scan_ff;

   // per request flags
   logic          preempt_ff, changed_ff;
   status_type    status_ff;
   logic [15:0]   assigned_ff;
   logic          old_vld_ff;
   logic [SW-1:0] old_slot_ff;
   logic [1:0]    old_base_ff;

   // result register
   logic        rsp_valid_ff;
   logic [15:0] rsp_id_ff, rsp_asg_ff;
   logic [1:0]  rsp_level_ff;
   logic        rsp_run_ff, rsp_sw_ff;
   status_type  rsp_status_ff;

   // slot memories
   logic [15:0]   ident_mem [JOB_SLOTS];
   logic [1:0]    base_mem  [JOB_SLOTS];
   logic [1:0]    level_mem [JOB_SLOTS];
   logic [3:0]    wait_mem  [JOB_SLOTS];
   logic [SW-1:0] link_mem  [JOB_SLOTS];
   logic [15:0]   rd_ident_ff;
   logic [1:0]    rd_base_ff, rd_level_ff;
   logic [3:0]    rd_wait_ff;
   logic [SW-1:0] rd_link_ff;
   logic [SW-1:0] rd_addr;

   // combinational helpers
   logic          tail_hit, nx_none, promote, id_match, scan_free;
   logic [3:0]    w_inc;
   logic [1:0]    lv_up, pick_lv;
   logic          pick_ok, need_sel;
   logic [3:0]    run_slice;
   logic [15:0]   next_ident;
   logic [SW-1:0] sel_head;
   logic          sel_hit;

   assign tail_hit   = !tail_none_ff[lv_ff] && (tail_ff[lv_ff] == p_ff);
   assign nx_none    = tail_hit;
   assign w_inc      = (rd_wait_ff == CNT_MAX) ? CNT_MAX : rd_wait_ff + 4'd1;
   assign promote    = (lv_ff != TOP_LEVEL) && (w_inc >= aging_ff);
   assign id_match   = (rd_ident_ff == id_ff);
   assign lv_up      = lv_ff + 2'd1;
   assign scan_free  = !used_ff[scan_ff];
   assign next_ident = (last_ident_ff == 16'hFFFF) ? 16'd1 : last_ident_ff + 16'd1;
   assign sel_head   = head_ff[lv_ff];
   assign sel_hit    = !tail_none_ff[lv_ff] && (tail_ff[lv_ff] == sel_head);

   always_comb begin
      case (run_level_ff)
         2'd0:    run_slice = slice_ff[0];
         2'd1:    run_slice = slice_ff[1];
         default: run_slice = slice_ff[2];
      endcase
   end

   // highest non-empty level not below the running level
   always_comb begin
      pick_ok = 1'b0;
      pick_lv = 2'd0;
      for (int l = 2; l >= 0; l--) begin
         if (!pick_ok && !head_none_ff[l] && (!run_vld_ff || 2'(l) >= run_level_ff)) begin
            pick_ok = 1'b1;
            pick_lv = 2'(l);
         end
      end
   end

   assign need_sel = preempt_ff || !run_vld_ff || (slice_used_ff >= run_slice);
   assign rd_addr  = (cmd == CMD_SEL_RD) ? head_ff[pick_lv] : p_ff;

   always_comb begin
      stat.op        = op_ff;
      stat.p_none    = p_none_ff;
      stat.lv_zero   = (lv_ff == 2'd0);
      stat.promote   = promote;
      stat.scan_free = scan_free;
      stat.scan_last = (scan_ff == LAST_SLOT);
      stat.run_vld   = run_vld_ff;
      stat.run_match = run_vld_ff && (run_ident_ff == id_ff);
      stat.id_match  = id_match;
      stat.need_sel  = need_sel;
      stat.pick_ok   = pick_ok;
      stat.out_free  = !rsp_valid_ff || rsp_tready;
   end

   // memory write ports
   logic          link_we, wait_we, level_we, ent_we;
   logic [SW-1:0] link_wa, wait_wa, level_wa, link_wd;
   logic [3:0]    wait_wd;
   logic [1:0]    level_wd;

   always_comb begin
      link_we  = 1'b0; link_wa  = p_ff;  link_wd  = rd_link_ff;
      wait_we  = 1'b0; wait_wa  = p_ff;  wait_wd  = 4'd0;
      level_we = 1'b0; level_wa = p_ff;  level_wd = lv_up;
      ent_we   = 1'b0;
      case (cmd)
         CMD_AGE_EX: begin
            wait_we = 1'b1;
            wait_wd = promote ? 4'd0 : w_inc;
            if (promote) begin
               level_we = 1'b1;
               link_we  = !prev_none_ff && !nx_none;
               link_wa  = prev_ff;
            end
         end
         CMD_DEQ_EX: begin
            link_we = id_match && !prev_none_ff && !nx_none;
            link_wa = prev_ff;
         end
         CMD_AGE_PUSH: begin
            link_we = !head_none_ff[lv_up];
            link_wa = pp_ff;
            link_wd = head_ff[lv_up];
         end
         CMD_SCAN: begin
            ent_we   = scan_free;
            wait_we  = scan_free;
            wait_wa  = scan_ff;
            level_we = scan_free;
            level_wa = scan_ff;
            level_wd = pr_ff;
            link_we  = scan_free && !head_none_ff[pr_ff];
            link_wa  = scan_ff;
            link_wd  = head_ff[pr_ff];
         end
         CMD_SEL_EX: begin
            wait_we = 1'b1;
            wait_wa = sel_head;
         end
         CMD_SEL_PUSH: begin
            wait_we  = 1'b1;
            wait_wa  = old_slot_ff;
            level_we = 1'b1;
            level_wa = old_slot_ff;
            level_wd = old_base_ff;
            link_we  = !head_none_ff[old_base_ff];
            link_wa  = tail_ff[old_base_ff];
            link_wd  = old_slot_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (link_we)  link_mem[link_wa]   <= link_wd;
      if (wait_we)  wait_mem[wait_wa]   <= wait_wd;
      if (level_we) level_mem[level_wa] <= level_wd;
      if (ent_we) begin
         ident_mem[scan_ff] <= next_ident;
         base_mem[scan_ff]  <= pr_ff;
      end
      rd_ident_ff <= ident_mem[rd_addr];
      rd_base_ff  <= base_mem[rd_addr];
      rd_level_ff <= level_mem[rd_addr];
      rd_wait_ff  <= wait_mem[rd_addr];
      rd_link_ff  <= link_mem[rd_addr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff[0] <= 4'd5;
         slice_ff[1] <= 4'd2;
         slice_ff[2] <= 4'd1;
         aging_ff    <= 4'd10;
      end else if (csr_we) begin
         case (cfg_index_type'(csr_index))
            CFG_SLICE0: slice_ff[0] <= csr_wdata;
            CFG_SLICE1: slice_ff[1] <= csr_wdata;
            CFG_SLICE2: slice_ff[2] <= csr_wdata;
            CFG_AGING:  aging_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // payload and cursor registers
   always_ff @(posedge clock) begin
      case (cmd)
         CMD_ACCEPT: begin
            op_ff       <= op_type'(req_tdata[1:0]);
            pr_ff       <= (req_tdata[3:2] == 2'd3) ? TOP_LEVEL : req_tdata[3:2];
            id_ff       <= req_tdata[19:4];
            scan_ff     <= '0;
            preempt_ff  <= 1'b0;
            changed_ff  <= 1'b0;
            status_ff   <= STATUS_OK;
            assigned_ff <= 16'd0;
         end
         CMD_RELEASE: if (run_vld_ff) changed_ff <= 1'b1;
         CMD_TICK, CMD_WALK_INIT: begin
            lv_ff        <= TOP_LEVEL;
            p_ff         <= head_ff[TOP_LEVEL];
            p_none_ff    <= head_none_ff[TOP_LEVEL];
            prev_none_ff <= 1'b1;
         end
         CMD_NEXT_LV: begin
            lv_ff        <= lv_ff - 2'd1;
            p_ff         <= head_ff[lv_ff - 2'd1];
            p_none_ff    <= head_none_ff[lv_ff - 2'd1];
            prev_none_ff <= 1'b1;
         end
         CMD_AGE_EX: begin
            p_ff      <= rd_link_ff;
            p_none_ff <= nx_none;
            if (promote) begin
               pp_ff <= p_ff;
            end else begin
               prev_ff      <= p_ff;
               prev_none_ff <= 1'b0;
            end
         end
         CMD_DEQ_EX: begin
            if (!id_match) begin
               p_ff         <= rd_link_ff;
               p_none_ff    <= nx_none;
               prev_ff      <= p_ff;
               prev_none_ff <= 1'b0;
            end
         end
         CMD_SCAN: begin
            if (scan_free) begin
               assigned_ff <= next_ident;
               preempt_ff  <= run_vld_ff && (pr_ff >= run_level_ff);
            end else if (scan_ff == LAST_SLOT) begin
               status_ff <= STATUS_FULL;
            end else begin
               scan_ff <= scan_ff + SW'(1);
            end
         end
         CMD_NOT_FOUND: status_ff <= STATUS_NOT_FOUND;
         // the chosen level becomes the cursor for the head removal
         CMD_SEL_RD: lv_ff <= pick_lv;
         CMD_SEL_EX: begin
            changed_ff   <= 1'b1;
            old_vld_ff   <= run_vld_ff;
            old_slot_ff  <= run_slot_ff;
            old_base_ff  <= run_base_ff;
            run_slot_ff  <= sel_head;
            run_ident_ff <= rd_ident_ff;
            run_level_ff <= rd_level_ff;
            run_base_ff  <= rd_base_ff;
         end
         default: ;
      endcase
   end

   // control state: lists, running job, slot use, counters
   always_ff @(posedge clock) begin
      if (reset) begin
         head_none_ff  <= 3'b111;
         tail_none_ff  <= 3'b111;
         run_vld_ff    <= 1'b0;
         slice_used_ff <= 4'd0;
         last_ident_ff <= 16'd0;
         used_ff       <= '0;
      end else begin
         case (cmd)
            CMD_RELEASE: begin
               if (run_vld_ff) begin
                  used_ff[run_slot_ff] <= 1'b0;
                  run_vld_ff           <= 1'b0;
               end
            end
            CMD_TICK: begin
               if (run_vld_ff && slice_used_ff != CNT_MAX)
                  slice_used_ff <= slice_used_ff + 4'd1;
            end
            CMD_AGE_EX, CMD_DEQ_EX: begin
               if ((cmd == CMD_AGE_EX && promote) || (cmd == CMD_DEQ_EX && id_match)) begin
                  if (prev_none_ff) begin
                     head_ff[lv_ff]      <= rd_link_ff;
                     head_none_ff[lv_ff] <= nx_none;
                  end
                  if (prev_none_ff && nx_none) begin
                     tail_none_ff[lv_ff] <= 1'b1;
                  end else if (tail_hit) begin
                     tail_ff[lv_ff]      <= prev_ff;
                     tail_none_ff[lv_ff] <= prev_none_ff;
                  end
                  if (cmd == CMD_DEQ_EX) used_ff[p_ff] <= 1'b0;
               end
            end
            CMD_AGE_PUSH: begin
               head_ff[lv_up]      <= pp_ff;
               head_none_ff[lv_up] <= 1'b0;
               if (head_none_ff[lv_up]) begin
                  tail_ff[lv_up]      <= pp_ff;
                  tail_none_ff[lv_up] <= 1'b0;
               end
            end
            CMD_SCAN: begin
               if (scan_free) begin
                  used_ff[scan_ff]    <= 1'b1;
                  last_ident_ff       <= next_ident;
                  head_ff[pr_ff]      <= scan_ff;
                  head_none_ff[pr_ff] <= 1'b0;
                  if (head_none_ff[pr_ff]) begin
                     tail_ff[pr_ff]      <= scan_ff;
                     tail_none_ff[pr_ff] <= 1'b0;
                  end
               end
            end
            CMD_SEL_NONE: slice_used_ff <= 4'd0;
            CMD_SEL_EX: begin
               slice_used_ff <= 4'd0;
               run_vld_ff    <= 1'b1;
               if (sel_hit) begin
                  head_none_ff[lv_ff] <= 1'b1;
                  tail_none_ff[lv_ff] <= 1'b1;
               end else begin
                  head_ff[lv_ff] <= rd_link_ff;
               end
            end
            CMD_SEL_PUSH: begin
               if (old_vld_ff) begin
                  tail_ff[old_base_ff]      <= old_slot_ff;
                  tail_none_ff[old_base_ff] <= 1'b0;
                  if (head_none_ff[old_base_ff]) begin
                     head_ff[old_base_ff]      <= old_slot_ff;
                     head_none_ff[old_base_ff] <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd == CMD_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_OUT) begin
         rsp_run_ff    <= run_vld_ff;
         rsp_id_ff     <= run_vld_ff ? run_ident_ff : 16'd0;
         rsp_level_ff  <= run_vld_ff ? run_level_ff : 2'd0;
         rsp_sw_ff     <= changed_ff;
         rsp_asg_ff    <= assigned_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_status_ff, rsp_asg_ff, rsp_sw_ff, rsp_level_ff,
                        rsp_id_ff, rsp_run_ff};

   a_list_ends: assert property (@(posedge clock) disable iff (reset)
      head_none_ff == tail_none_ff)
      else $error("list head and tail disagree on emptiness");

   a_run_used: assert property (@(posedge clock) disable iff (reset)
      run_vld_ff |-> used_ff[run_slot_ff])
      else $error("running job sits in a free slot");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_OUT |=> rsp_valid_ff)
      else $error("result not presented after load");

endmodule

### sv/mlfq_job_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_job_scheduler_top
// three-level feedback queue scheduler over a table of job slots
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_*     in         operation, job_priority, job_id
//  rsp_*     out        run_valid, run_id, run_level, switched, assigned_id, status
//  csr_*     in         slice_level0..2, aging_limit (write only)
//
//  one request at a time: accept, decode, one check per level while aging,
//  where each queued job visited is read and updated and a promoted one is
//  pushed up a level (aging is skipped on finish), dispatch, then on enqueue a
//  scan of up to JOB_SLOTS slots for a free one, on dequeue one check per level
//  and a read per job visited, then a selection check, a head read and update
//  when a job is selected, a push of the job it replaces, and the result load
//  synchronous active-high reset empties all levels and clears the running job
//  a result waits in the output register while the next request is taken in
// ----------------------------------------------------------------------------
module mlfq_job_scheduler_top #(
   parameter int JOB_SLOTS = mlfq_pkg::JOB_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request: operation[1:0], job_priority[3:2], job_id[19:4]
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [mlfq_pkg::REQ_W-1:0]  req_tdata,
   // result: run_valid[0], run_id[16:1], run_level[18:17], switched[19],
   // assigned_id[35:20], status[37:36]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [mlfq_pkg::RSP_W-1:0]  rsp_tdata,
   // register write port
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [mlfq_pkg::CFG_W-1:0]  csr_wdata
);
   import mlfq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   mlfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // slot table, lists and result register
   mlfq_dpath #(
      .JOB_SLOTS (JOB_SLOTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
